@@ rtl/fastload_two_wire_byte_transceiver_defines.svh @@
// Assertion macros used by the transceiver core.
`ifndef FASTLOAD_TWO_WIRE_BYTE_TRANSCEIVER_DEFINES_SVH
`define FASTLOAD_TWO_WIRE_BYTE_TRANSCEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLTX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FLTX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fltx_pkg.sv @@
// Types and constants of the two-wire byte transceiver.
package fltx_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SEND = 2'd1;
  localparam logic [1:0] REQ_RECV = 2'd2;

  // status codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_SENT  = 2'd1;
  localparam logic [1:0] ST_RCVD  = 2'd2;
  localparam logic [1:0] ST_ABORT = 2'd3;

  // phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RX_W1  = 3'd1;
  localparam logic [2:0] PH_RX_W2  = 3'd2;
  localparam logic [2:0] PH_RX_RUN = 3'd3;
  localparam logic [2:0] PH_TX_W1  = 3'd4;
  localparam logic [2:0] PH_TX_W2  = 3'd5;
  localparam logic [2:0] PH_TX_RUN = 3'd6;

  localparam int TICK_W = 7;

  // receive sample points and end
  localparam logic [TICK_W-1:0] RX_S1   = 7'd14;
  localparam logic [TICK_W-1:0] RX_S2   = 7'd24;
  localparam logic [TICK_W-1:0] RX_S3   = 7'd38;
  localparam logic [TICK_W-1:0] RX_S4   = 7'd48;
  localparam logic [TICK_W-1:0] RX_DONE = 7'd68;

  // transmit bit-pair points and end
  localparam logic [TICK_W-1:0] TX_B1   = 7'd14;
  localparam logic [TICK_W-1:0] TX_B2   = 7'd22;
  localparam logic [TICK_W-1:0] TX_B3   = 7'd30;
  localparam logic [TICK_W-1:0] TX_B4   = 7'd38;
  localparam logic [TICK_W-1:0] TX_DONE = 7'd48;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       clk_level;
    logic       data_level;
    logic       atn_level;
    logic       reset_idle;
  } in_beat_t;

  typedef struct packed {
    logic       clk_drive;
    logic       data_drive;
    logic [7:0] rx_byte;
    logic [1:0] status;
    logic       busy_res;
  } result_t;

endpackage

@@ rtl/fltx_if.sv @@
// Valid/ready channel interfaces for the request and result beats.
interface fltx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] tx_byte;
  logic       clk_level;
  logic       data_level;
  logic       atn_level;
  logic       reset_idle;

  modport source (output valid, req_type, tx_byte, clk_level, data_level,
                  atn_level, reset_idle, input ready);
  modport sink (input valid, req_type, tx_byte, clk_level, data_level,
                atn_level, reset_idle, output ready);
endinterface

interface fltx_out_if;
  logic       valid;
  logic       ready;
  logic       clk_drive;
  logic       data_drive;
  logic [7:0] rx_byte;
  logic [1:0] status;
  logic       busy_res;

  modport source (output valid, clk_drive, data_drive, rx_byte, status, busy_res,
                  input ready);
  modport sink (input valid, clk_drive, data_drive, rx_byte, status, busy_res,
                output ready);
endinterface

@@ rtl/fltx_core.sv @@
// Protocol state and per-beat next-state logic.
`include "fastload_two_wire_byte_transceiver_defines.svh"

module fltx_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  fltx_pkg::in_beat_t beat,
  output fltx_pkg::result_t  res
);
  import fltx_pkg::*;

  logic [2:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [7:0]        shift_r, shift_nxt, smp, swp;
  logic              clk_out_r, clk_out_nxt;
  logic              data_out_r, data_out_nxt;
  logic              abort_req, do_abort;
  logic [1:0]        status;
  logic [7:0]        rx;

  assign abort_req = !beat.atn_level || !beat.reset_idle;
  assign tick_inc  = tick_r + 7'd1;
  // OR in the DATA sample at bit 0 and the CLK sample at bit 2
  assign smp = shift_r | {5'b0, beat.clk_level, 1'b0, beat.data_level};
  assign swp = {smp[3:0], smp[7:4]};

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    clk_out_nxt  = clk_out_r;
    data_out_nxt = data_out_r;
    status       = ST_NONE;
    rx           = 8'd0;
    do_abort     = 1'b0;
    unique case (beat.req_type)
      REQ_SEND: begin
        if (phase_r == PH_IDLE) begin
          shift_nxt    = ~beat.tx_byte;
          tick_nxt     = '0;
          data_out_nxt = 1'b0;
          clk_out_nxt  = 1'b1;
          phase_nxt    = PH_TX_W1;
        end
      end
      REQ_RECV: begin
        if (phase_r == PH_IDLE) begin
          shift_nxt    = 8'd0;
          tick_nxt     = '0;
          clk_out_nxt  = 1'b0;
          data_out_nxt = 1'b1;
          phase_nxt    = PH_RX_W1;
        end
      end
      REQ_TICK: begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_RX_W1: begin
            // DATA low ends wait 1; wait 2 then sees the same low sample
            if (beat.data_level) begin
              do_abort = abort_req;
            end else if (abort_req) begin
              do_abort = 1'b1;
            end else begin
              clk_out_nxt = 1'b1;
              phase_nxt   = PH_RX_W2;
            end
          end
          PH_RX_W2: begin
            if (!beat.data_level) begin
              do_abort = abort_req;
            end else begin
              tick_nxt  = '0;
              shift_nxt = 8'd0;
              phase_nxt = PH_RX_RUN;
            end
          end
          PH_RX_RUN: begin
            tick_nxt = tick_inc;
            if (tick_inc == RX_S1) begin
              shift_nxt = smp << 1;
            end else if (tick_inc == RX_S2) begin
              shift_nxt = swp >> 1;
            end else if (tick_inc == RX_S3) begin
              shift_nxt = smp << 1;
            end else if (tick_inc == RX_S4) begin
              shift_nxt = smp;
            end else if (tick_inc >= RX_DONE) begin
              rx        = ~shift_r;
              status    = ST_RCVD;
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end
          end
          PH_TX_W1: begin
            if (beat.clk_level) begin
              do_abort = abort_req;
            end else if (abort_req) begin
              do_abort = 1'b1;
            end else begin
              data_out_nxt = 1'b1;
              phase_nxt    = PH_TX_W2;
            end
          end
          PH_TX_W2: begin
            if (!beat.clk_level) begin
              do_abort = abort_req;
            end else begin
              tick_nxt  = '0;
              phase_nxt = PH_TX_RUN;
            end
          end
          PH_TX_RUN: begin
            tick_nxt = tick_inc;
            if (tick_inc == TX_B1 || tick_inc == TX_B2 ||
                tick_inc == TX_B3 || tick_inc == TX_B4) begin
              clk_out_nxt  = shift_r[0];
              data_out_nxt = shift_r[1];
              shift_nxt    = shift_r >> 2;
            end else if (tick_inc >= TX_DONE) begin
              clk_out_nxt  = 1'b1;
              data_out_nxt = 1'b1;
              status       = ST_SENT;
              phase_nxt    = PH_IDLE;
              tick_nxt     = '0;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    if (do_abort) begin
      clk_out_nxt  = 1'b1;
      data_out_nxt = 1'b1;
      phase_nxt    = PH_IDLE;
      status       = ST_ABORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      shift_r    <= 8'd0;
      clk_out_r  <= 1'b1;
      data_out_r <= 1'b1;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      shift_r    <= shift_nxt;
      clk_out_r  <= clk_out_nxt;
      data_out_r <= data_out_nxt;
    end
  end

  assign res.clk_drive  = clk_out_nxt;
  assign res.data_drive = data_out_nxt;
  assign res.rx_byte    = rx;
  assign res.status     = status;
  assign res.busy_res   = (phase_nxt != PH_IDLE);

  `FLTX_ASSERT_IMP(a_idle_released, clk, rst_n, phase_r == PH_IDLE,
    clk_out_r && data_out_r, "lines held while idle")
  `FLTX_ASSERT_IMP(a_rx_tick_bound, clk, rst_n, phase_r == PH_RX_RUN,
    tick_r < RX_DONE, "receive tick count past end")
  `FLTX_ASSERT_IMP(a_rcvd_from_run, clk, rst_n, step_en && res.status == ST_RCVD,
    phase_r == PH_RX_RUN, "receive done outside run phase")
  `FLTX_ASSERT_NXT(a_done_goes_idle, clk, rst_n, step_en && res.status != ST_NONE,
    phase_r == PH_IDLE, "finished transfer left busy")

endmodule

@@ rtl/fltx_out_reg.sv @@
// Result register between the step logic and the result channel.
module fltx_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fltx_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output fltx_pkg::result_t out_res
);
  import fltx_pkg::*;

  logic    valid_r;
  result_t res_r;

  // take a new beat when empty or when the held one leaves this cycle
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

@@ rtl/fastload_two_wire_byte_transceiver.sv @@
// Top level of the two-wire fast-loader byte transceiver.
// Every request beat (a one-microsecond tick with sampled CLK, DATA, ATN and
// bus reset levels, or a send/receive start) yields exactly one result beat
// carrying the line drives, status and busy flag. One beat is accepted per
// clock: the whole protocol step is a short decode between the state
// registers in the core and a single result register, so the result appears
// on out_ch in the cycle after acceptance. in_ch.ready drops only while a
// result sits in the output register and out_ch.ready is low.
module fastload_two_wire_byte_transceiver (
  input  logic       clk,
  input  logic       rst_n,
  fltx_in_if.sink    in_ch,
  fltx_out_if.source out_ch
);
  import fltx_pkg::*;

  in_beat_t beat;
  result_t  step_res;
  result_t  held_res;
  logic     in_ready;
  logic     step_en;

  // pack the request beat
  assign beat.req_type   = in_ch.req_type;
  assign beat.tx_byte    = in_ch.tx_byte;
  assign beat.clk_level  = in_ch.clk_level;
  assign beat.data_level = in_ch.data_level;
  assign beat.atn_level  = in_ch.atn_level;
  assign beat.reset_idle = in_ch.reset_idle;

  assign in_ch.ready = in_ready;
  // protocol state advances only on an accepted beat
  assign step_en = in_ch.valid && in_ready;

  fltx_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .beat    (beat),
    .res     (step_res)
  );

  fltx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_res    (step_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (held_res)
  );

  // unpack the result beat
  assign out_ch.clk_drive  = held_res.clk_drive;
  assign out_ch.data_drive = held_res.data_drive;
  assign out_ch.rx_byte    = held_res.rx_byte;
  assign out_ch.status     = held_res.status;
  assign out_ch.busy_res   = held_res.busy_res;

endmodule

@@ sim/fltx_checker.sv @@
// Beat monitor, transceiver predictor and result scoreboard.
module fltx_checker (
  input  logic clk,
  input  logic rst_n,
  fltx_in_if   in_mon,
  fltx_out_if  out_mon,
  output int   pending,
  output int   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fltx_pkg::*;

  // predicted transceiver state
  logic [2:0]        line_phase;
  logic [TICK_W-1:0] tick_cnt;
  logic [7:0]        shifter;
  logic              clk_line;
  logic              data_line;

  result_t due_q[$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  function automatic void free_lines();
    clk_line   = 1'b1;
    data_line  = 1'b1;
    line_phase = PH_IDLE;
  endfunction

  function automatic void take_sample(in_beat_t b);
    if (b.data_level) shifter[0] = 1'b1;
    if (b.clk_level)  shifter[2] = 1'b1;
  endfunction

  // One beat of protocol; returns the result beat it causes.
  function automatic result_t advance_transceiver(in_beat_t b);
    result_t r;
    logic    aborting;
    logic    held;
    aborting = !b.atn_level || !b.reset_idle;
    held     = 1'b0;
    r        = '0;
    r.status = ST_NONE;
    case (b.req_type)
      REQ_SEND: if (line_phase == PH_IDLE) begin
        shifter    = ~b.tx_byte;
        tick_cnt   = '0;
        data_line  = 1'b0;
        clk_line   = 1'b1;
        line_phase = PH_TX_W1;
      end
      REQ_RECV: if (line_phase == PH_IDLE) begin
        shifter    = '0;
        tick_cnt   = '0;
        clk_line   = 1'b0;
        data_line  = 1'b1;
        line_phase = PH_RX_W1;
      end
      REQ_TICK: begin
        case (line_phase)
          PH_RX_W1, PH_RX_W2: begin
            if (line_phase == PH_RX_W1) begin
              if (b.data_level) begin
                held = 1'b1;
                if (aborting) begin
                  free_lines();
                  r.status = ST_ABORT;
                end
              end else begin
                clk_line   = 1'b1;
                line_phase = PH_RX_W2;
              end
            end
            // second wait judged on the same samples
            if (!held) begin
              if (!b.data_level) begin
                if (aborting) begin
                  free_lines();
                  r.status = ST_ABORT;
                end
              end else begin
                tick_cnt   = '0;
                shifter    = '0;
                line_phase = PH_RX_RUN;
              end
            end
          end
          PH_RX_RUN: begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt == RX_S1) begin
              take_sample(b);
              shifter = shifter << 1;
            end else if (tick_cnt == RX_S2) begin
              take_sample(b);
              shifter = {shifter[3:0], shifter[7:4]};
              shifter = shifter >> 1;
            end else if (tick_cnt == RX_S3) begin
              take_sample(b);
              shifter = shifter << 1;
            end else if (tick_cnt == RX_S4) begin
              take_sample(b);
            end else if (tick_cnt >= RX_DONE) begin
              r.rx_byte  = ~shifter;
              r.status   = ST_RCVD;
              line_phase = PH_IDLE;
              tick_cnt   = '0;
            end
          end
          PH_TX_W1, PH_TX_W2: begin
            if (line_phase == PH_TX_W1) begin
              if (b.clk_level) begin
                held = 1'b1;
                if (aborting) begin
                  free_lines();
                  r.status = ST_ABORT;
                end
              end else begin
                data_line  = 1'b1;
                line_phase = PH_TX_W2;
              end
            end
            if (!held) begin
              if (!b.clk_level) begin
                if (aborting) begin
                  free_lines();
                  r.status = ST_ABORT;
                end
              end else begin
                tick_cnt   = '0;
                line_phase = PH_TX_RUN;
              end
            end
          end
          PH_TX_RUN: begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt == TX_B1 || tick_cnt == TX_B2 ||
                tick_cnt == TX_B3 || tick_cnt == TX_B4) begin
              clk_line  = shifter[0];
              data_line = shifter[1];
              shifter   = shifter >> 2;
            end else if (tick_cnt >= TX_DONE) begin
              free_lines();
              r.status = ST_SENT;
              tick_cnt = '0;
            end
          end
          default: line_phase = PH_IDLE;
        endcase
      end
      default: ;  // unused request code: ignored
    endcase
    r.clk_drive  = clk_line;
    r.data_drive = data_line;
    r.busy_res   = (line_phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track_beats
    result_t  want;
    result_t  got;
    in_beat_t beat;
    if (!rst_n) begin
      line_phase = PH_IDLE;
      tick_cnt   = '0;
      shifter    = '0;
      clk_line   = 1'b1;
      data_line  = 1'b1;
      due_q.delete();
      pending <= 0;
    end else begin
      // results first: a beat accepted on this edge cannot have its result yet
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.clk_drive, out_mon.data_drive, out_mon.rx_byte,
               out_mon.status, out_mon.busy_res};
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          check_field("clk_drive",  want.clk_drive,  got.clk_drive);
          check_field("data_drive", want.data_drive, got.data_drive);
          check_field("rx_byte",    want.rx_byte,    got.rx_byte);
          check_field("status",     want.status,     got.status);
          check_field("busy_res",   want.busy_res,   got.busy_res);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat = {in_mon.req_type, in_mon.tx_byte, in_mon.clk_level,
                in_mon.data_level, in_mon.atn_level, in_mon.reset_idle};
        due_q.push_back(advance_transceiver(beat));
      end
      pending <= due_q.size();
    end
  end

endmodule

@@ sim/fastload_two_wire_byte_transceiver_tb.sv @@
// Top of the transceiver testbench: clock, reset, beat stimulus and verdict.
module fastload_two_wire_byte_transceiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fltx_pkg::*;

  // request code the block has no use for; must be ignored
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 1550;
  localparam int MAX_WAIT       = 18;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  fltx_in_if  in_ch ();
  fltx_out_if out_ch ();

  int pending;
  int fail_count;
  int beats_sent = 0;
  int idle_cycles = 0;
  bit src_burst = 1'b0;  // sender in a no-gap stretch
  bit snk_burst = 1'b0;  // receiver in a no-stall stretch

  fastload_two_wire_byte_transceiver uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fltx_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("** fastload_two_wire_byte_transceiver: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  // Tick beat with given line levels (CLK, DATA, ATN, bus reset idle).
  function automatic in_beat_t line_tick(bit c, bit d, bit a, bit r);
    in_beat_t b;
    b.req_type   = REQ_TICK;
    b.tx_byte    = 8'($urandom_range(0, 255));  // don't-care on a tick
    b.clk_level  = c;
    b.data_level = d;
    b.atn_level  = a;
    b.reset_idle = r;
    return b;
  endfunction

  function automatic in_beat_t rand_tick();
    return line_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Start request (or unused code) with random line levels.
  function automatic in_beat_t mk_start(logic [1:0] req, logic [7:0] byte_val);
    in_beat_t b;
    b          = rand_tick();
    b.req_type = req;
    b.tx_byte  = byte_val;
    return b;
  endfunction

  // Handshake-wait tick: the line the block is watching (CLK on a send, DATA
  // on a receive) is set to lvl. With pull_abort, ATN and/or bus reset go low.
  function automatic in_beat_t wait_tick(bit sending, bit lvl, bit pull_abort);
    in_beat_t b;
    b = rand_tick();
    if (sending) b.clk_level = lvl;
    else         b.data_level = lvl;
    if (pull_abort) begin
      case ($urandom_range(0, 2))
        0:       begin b.atn_level = 1'b0; b.reset_idle = 1'b1; end
        1:       begin b.atn_level = 1'b1; b.reset_idle = 1'b0; end
        default: begin b.atn_level = 1'b0; b.reset_idle = 1'b0; end
      endcase
    end else begin
      b.atn_level  = 1'b1;
      b.reset_idle = 1'b1;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: inputs change on the falling edge, handshakes judged on the rising
  // edge. Each beat gets a random lead-in gap; now and then the sender enters
  // a stretch with no gaps at all.
  // ---------------------------------------------------------------------------
  task automatic push_beat(in_beat_t b, bit counted);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= b.req_type;
    in_ch.tx_byte    <= b.tx_byte;
    in_ch.clk_level  <= b.clk_level;
    in_ch.data_level <= b.data_level;
    in_ch.atn_level  <= b.atn_level;
    in_ch.reset_idle <= b.reset_idle;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) beats_sent++;
  endtask

  // Occasional start request slipped into a busy transfer: must be ignored
  // and must not advance the tick count.
  task automatic maybe_stray();
    if ($urandom_range(0, 15) == 0)
      push_beat(mk_start(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255))), 1'b1);
  endtask

  // Drop valid and hold the sender until the scoreboard is empty. The first
  // edge lets a beat accepted on the previous edge show up in the count.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One transfer from start request to idle.
  // Well-formed: both handshake waits pass (with a few waiting ticks each),
  // then a full run of ticks with random line content.
  // Broken: ATN or bus reset drops during one of the waits; aborts either in
  // the first wait, on the tick that ends the first wait (same-tick check of
  // the second wait), or later in the second wait.
  task automatic run_transfer(bit sending, bit broken);
    int stop_at;
    stop_at = $urandom_range(0, 2);
    push_beat(mk_start(sending ? REQ_SEND : REQ_RECV, 8'($urandom_range(0, 255))), 1'b1);

    // first wait: watched line still high
    repeat ($urandom_range(0, 4)) begin
      maybe_stray();
      push_beat(wait_tick(sending, 1'b1, 1'b0), 1'b1);
    end
    if (broken && stop_at == 0) begin
      push_beat(wait_tick(sending, 1'b1, 1'b1), 1'b1);
      return;
    end

    // watched line goes low: first wait ends
    if (broken && stop_at == 1) begin
      push_beat(wait_tick(sending, 1'b0, 1'b1), 1'b1);
      return;
    end
    push_beat(wait_tick(sending, 1'b0, 1'b0), 1'b1);

    // second wait: watched line still low
    repeat ($urandom_range(0, 4)) begin
      maybe_stray();
      push_beat(wait_tick(sending, 1'b0, 1'b0), 1'b1);
    end
    if (broken) begin
      push_beat(wait_tick(sending, 1'b0, 1'b1), 1'b1);
      return;
    end

    // watched line back high: count starts; ATN/reset are not looked at
    push_beat(wait_tick(sending, 1'b1, 1'($urandom_range(0, 1))), 1'b1);

    // 48 ticks to finish a send, 68 a receive; nothing aborts in here
    repeat (sending ? int'(TX_DONE) : int'(RX_DONE)) begin
      maybe_stray();
      push_beat(rand_tick(), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each result beat, with stall-free
  // stretches mixed in.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_TICK;
    in_ch.tx_byte    = '0;
    in_ch.clk_level  = 1'b1;
    in_ch.data_level = 1'b1;
    in_ch.atn_level  = 1'b1;
    in_ch.reset_idle = 1'b1;
    rst_n            = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // ticks while idle change nothing, whatever the lines say
    push_beat(line_tick(1'b1, 1'b1, 1'b1, 1'b1), 1'b1);
    push_beat(line_tick(1'b0, 1'b0, 1'b0, 1'b0), 1'b1);
    push_beat(mk_start(REQ_UNUSED, 8'hA5), 1'b1);
    // receive; further starts while busy are ignored
    push_beat(mk_start(REQ_RECV, 8'h00), 1'b1);
    push_beat(mk_start(REQ_SEND, 8'hFF), 1'b1);
    push_beat(mk_start(REQ_RECV, 8'hFF), 1'b1);
    push_beat(mk_start(REQ_UNUSED, 8'h00), 1'b1);
    push_beat(line_tick(1'b0, 1'b1, 1'b1, 1'b1), 1'b1);   // DATA still high: keep waiting
    push_beat(line_tick(1'b0, 1'b1, 1'b0, 1'b1), 1'b1);   // ATN low in first receive wait
    // send with all-ones byte, aborted by bus reset in first wait
    push_beat(mk_start(REQ_SEND, 8'hFF), 1'b1);
    push_beat(line_tick(1'b1, 1'b0, 1'b1, 1'b1), 1'b1);
    push_beat(line_tick(1'b1, 1'b1, 1'b1, 1'b0), 1'b1);
    // receive aborted by bus reset in the second wait
    push_beat(mk_start(REQ_RECV, 8'h5A), 1'b1);
    push_beat(line_tick(1'b1, 1'b0, 1'b1, 1'b1), 1'b1);   // DATA low: CLK released
    push_beat(line_tick(1'b1, 1'b0, 1'b1, 1'b1), 1'b1);
    push_beat(line_tick(1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    // same-tick check: first wait ends, second one aborts on the same samples
    push_beat(mk_start(REQ_RECV, 8'h3C), 1'b1);
    push_beat(line_tick(1'b1, 1'b0, 1'b0, 1'b1), 1'b1);
    push_beat(mk_start(REQ_SEND, 8'h00), 1'b1);
    push_beat(line_tick(1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    // send aborted by ATN in the second wait
    push_beat(mk_start(REQ_SEND, 8'h5A), 1'b1);
    push_beat(line_tick(1'b0, 1'b1, 1'b1, 1'b1), 1'b1);
    push_beat(line_tick(1'b0, 1'b0, 1'b0, 1'b1), 1'b1);
    drain_results();

    // --- random: mostly complete transfers, some aborted, some idle noise ---
    while (beats_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3)
        run_transfer(1'b0, 1'b0);
      else if (pick <= 6)
        run_transfer(1'b1, 1'b0);
      else if (pick <= 8)
        run_transfer(1'($urandom_range(0, 1)), 1'b1);
      else
        repeat ($urandom_range(1, 6))
          push_beat(mk_start($urandom_range(0, 1) ? REQ_TICK : REQ_UNUSED,
                             8'($urandom_range(0, 255))), 1'b1);
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("** fastload_two_wire_byte_transceiver: PASSED **");
    else
      $display("** fastload_two_wire_byte_transceiver: FAILED **");
    $finish;
  end

endmodule

@@ fastload_two_wire_byte_transceiver.f @@
+incdir+rtl
rtl/fltx_pkg.sv
rtl/fltx_if.sv
rtl/fltx_core.sv
rtl/fltx_out_reg.sv
rtl/fastload_two_wire_byte_transceiver.sv
sim/fltx_checker.sv
sim/fastload_two_wire_byte_transceiver_tb.sv
